>>> design/redundant_sensor_health_monitor_core_assert.svh
// Assertion helpers for the monitor core RTL.
`ifndef REDUNDANT_SENSOR_HEALTH_MONITOR_CORE_ASSERT_SVH
`define REDUNDANT_SENSOR_HEALTH_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RSHM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define RSHM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rshm_pkg.sv
`default_nettype none

package rshm_pkg;

    // Number of redundant sensor slots carried by one request.
    localparam int SLOT_COUNT = 4;

    // Field widths.
    localparam int ID_W     = 32;
    localparam int INCONS_W = 16;
    localparam int LEVEL_W  = 15;
    localparam int RATIO_W  = 12;
    localparam int HOLD_W   = 24;
    localparam int TIME_W   = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Q4.8 value of 1.0.
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(256);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARN_LEVEL     = 2'd0,
        CFG_CRITICAL_LEVEL = 2'd1,
        CFG_MARGIN_RATIO   = 2'd2,
        CFG_HOLD_TIME_US   = 2'd3
    } cfg_idx_t;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] WARN_LEVEL_RST     = LEVEL_W'(256);
    localparam logic [LEVEL_W-1:0] CRITICAL_LEVEL_RST = LEVEL_W'(512);
    localparam logic [RATIO_W-1:0] MARGIN_RATIO_RST   = RATIO_W'(204);
    localparam logic [HOLD_W-1:0]  HOLD_TIME_US_RST   = HOLD_W'(1000000);

    // Severity codes.
    typedef enum logic [1:0] {
        SEV_INFO     = 2'd0,
        SEV_WARN     = 2'd1,
        SEV_CRITICAL = 2'd2
    } sev_t;

    // What one slot lane reports.
    typedef struct packed {
        logic               populated;
        logic               unhealthy;
        logic               primary_bad;
        logic [LEVEL_W-1:0] incons;     // clamped at zero, zero when empty
    } lane_res_t;

    // What the merge stage reports for one request.
    typedef struct packed {
        logic raw_failure;
        sev_t severity;
        logic low_margin;
    } merge_res_t;

endpackage

`default_nettype wire

>>> design/rshm_lane.sv
`default_nettype none

module rshm_lane (
    input  wire logic [rshm_pkg::ID_W-1:0]            id,
    input  wire logic [rshm_pkg::ID_W-1:0]            primary_dev,
    input  wire logic                                 healthy,
    input  wire logic signed [rshm_pkg::INCONS_W-1:0] incons,
    output rshm_pkg::lane_res_t                       res
);
    import rshm_pkg::*;

    logic populated;

    // Skip empty slots; flag unhealthy ones and a bad primary.
    assign populated = (id != '0);

    // Clamp negative inconsistency to zero; empty slot contributes zero.
    assign res = '{
        populated:   populated,
        unhealthy:   populated && !healthy,
        primary_bad: populated && !healthy && (id == primary_dev),
        incons:      (!populated || incons[INCONS_W-1]) ? '0 : incons[LEVEL_W-1:0]
    };

endmodule

`default_nettype wire

>>> design/rshm_merge.sv
`default_nettype none

module rshm_merge (
    input  wire rshm_pkg::lane_res_t           lanes [rshm_pkg::SLOT_COUNT],
    input  wire logic [rshm_pkg::LEVEL_W-1:0]  warn_level,
    input  wire logic [rshm_pkg::LEVEL_W-1:0]  critical_level,
    input  wire logic [rshm_pkg::RATIO_W-1:0]  margin_ratio,
    output rshm_pkg::merge_res_t               res
);
    import rshm_pkg::*;

    localparam int PROD_W = RATIO_W + LEVEL_W;

    logic [SLOT_COUNT-1:0] pop_vec;
    logic [SLOT_COUNT-1:0] unh_vec;
    logic [SLOT_COUNT-1:0] pbad_vec;
    logic [LEVEL_W-1:0]    max_incons;
    logic                  all_bad;
    logic                  over_crit;
    logic                  over_warn;
    logic [LEVEL_W-1:0]    range;
    logic                  range_pos;
    logic [LEVEL_W-1:0]    over_amt;
    logic [PROD_W-1:0]     info_thr;
    logic [PROD_W-1:0]     warn_thr;
    logic                  info_low;
    logic                  warn_low;
    logic                  low_sel;
    sev_t                  sev;

    // Gather lane flags and take the largest inconsistency.
    always_comb
    begin
        max_incons = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            pop_vec[i]  = lanes[i].populated;
            unh_vec[i]  = lanes[i].unhealthy;
            pbad_vec[i] = lanes[i].primary_bad;
            if (lanes[i].incons > max_incons)
            begin
                max_incons = lanes[i].incons;
            end
        end
    end

    // Classify severity.
    assign all_bad   = (|pop_vec) && ((pop_vec & ~unh_vec) == '0);
    assign over_crit = max_incons > critical_level;
    assign over_warn = max_incons > warn_level;

    always_comb
    begin
        if ((|pbad_vec) || all_bad || over_crit)
        begin
            sev = SEV_CRITICAL;
        end
        else if ((|unh_vec) || over_warn)
        begin
            sev = SEV_WARN;
        end
        else
        begin
            sev = SEV_INFO;
        end
    end

    // Margin thresholds by cross-multiplication.
    assign range_pos = critical_level > warn_level;
    assign range     = critical_level - warn_level;
    assign over_amt  = max_incons - warn_level;
    assign info_thr  = PROD_W'(margin_ratio) * PROD_W'(warn_level);
    assign warn_thr  = PROD_W'(margin_ratio) * PROD_W'(range);

    assign info_low = (warn_level != '0) && (PROD_W'({max_incons, 8'h00}) > info_thr);
    assign warn_low = range_pos ? (over_warn && (PROD_W'({over_amt, 8'h00}) > warn_thr))
                                : (margin_ratio < RATIO_ONE);

    // Pick the margin for the chosen severity.
    always_comb
    begin
        unique case (sev)
            SEV_INFO: low_sel = info_low;
            SEV_WARN: low_sel = warn_low;
            default:  low_sel = 1'b1;
        endcase
    end

    assign res = '{
        raw_failure: |unh_vec,
        severity:    sev,
        low_margin:  low_sel
    };

endmodule

`default_nettype wire

>>> design/redundant_sensor_health_monitor_core.sv
// Redundant sensor health monitor.
// Input channel (in_valid/in_ready): one request carries four slot ids, the
// primary id, a healthy mask, four signed Q8.8 inconsistencies and a 48-bit
// microsecond timestamp. Output channel (out_valid/out_ready): one result
// per request: raw_failure, ok_flag, severity and low_margin.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 warn_level, 1 critical_level, 2 margin_ratio, 3 hold_time_us) at once;
// write only while no request is in flight.
// Pipeline: an accepted request is registered in the lane stage, then its
// result in the output register (one lane register stage, one output
// register). Throughput: one request per cycle while out_ready is high,
// set by the four slot lanes working side by side and a hysteresis update
// in the merge stage.
// Reset: configuration returns to its defaults, the failure filter is clear
// and both pipeline stages are empty.
// Stall: with out_ready low the result holds; one more request can wait in
// the lane stage, after which in_ready drops until the result is taken.
`default_nettype none

`include "redundant_sensor_health_monitor_core_assert.svh"

module redundant_sensor_health_monitor_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_wdata,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        id_slot0,
    input  wire logic [31:0]        id_slot1,
    input  wire logic [31:0]        id_slot2,
    input  wire logic [31:0]        id_slot3,
    input  wire logic [31:0]        primary_device,
    input  wire logic [3:0]         healthy_mask,
    input  wire logic signed [15:0] incons_slot0,
    input  wire logic signed [15:0] incons_slot1,
    input  wire logic signed [15:0] incons_slot2,
    input  wire logic signed [15:0] incons_slot3,
    input  wire logic [47:0]        time_us,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    raw_failure,
    output logic                    ok_flag,
    output logic [1:0]              severity,
    output logic                    low_margin
);
    import rshm_pkg::*;

    // configuration
    logic [LEVEL_W-1:0] warn_level_reg;
    logic [LEVEL_W-1:0] critical_level_reg;
    logic [RATIO_W-1:0] margin_ratio_reg;
    logic [HOLD_W-1:0]  hold_time_us_reg;

    // lanes
    logic [ID_W-1:0]            ids     [SLOT_COUNT];
    logic signed [INCONS_W-1:0] incons  [SLOT_COUNT];
    lane_res_t                  lane_res [SLOT_COUNT];

    // lane stage
    logic                s1_valid_reg;
    lane_res_t           s1_lanes_reg [SLOT_COUNT];
    logic [TIME_W-1:0]   s1_time_reg;
    logic                s1_adv;
    logic                in_fire;
    merge_res_t          merged;

    // hysteresis state
    logic                filt_reg;
    logic                filt_next;
    logic                req_reg;
    logic                req_next;
    logic [TIME_W-1:0]   req_time_reg;
    logic [TIME_W-1:0]   req_time_next;
    logic [TIME_W-1:0]   elapsed;

    // output stage
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                raw_reg;
    logic                ok_reg;
    sev_t                sev_reg;
    logic                low_reg;

    // Hold configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_level_reg     <= WARN_LEVEL_RST;
            critical_level_reg <= CRITICAL_LEVEL_RST;
            margin_ratio_reg   <= MARGIN_RATIO_RST;
            hold_time_us_reg   <= HOLD_TIME_US_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WARN_LEVEL:     warn_level_reg     <= cfg_wdata[LEVEL_W-1:0];
                CFG_CRITICAL_LEVEL: critical_level_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_MARGIN_RATIO:   margin_ratio_reg   <= cfg_wdata[RATIO_W-1:0];
                CFG_HOLD_TIME_US:   hold_time_us_reg   <= cfg_wdata[HOLD_W-1:0];
                default:            ;
            endcase
        end
    end

    // Spread the request over the slot lanes.
    assign ids[0]    = id_slot0;
    assign ids[1]    = id_slot1;
    assign ids[2]    = id_slot2;
    assign ids[3]    = id_slot3;
    assign incons[0] = incons_slot0;
    assign incons[1] = incons_slot1;
    assign incons[2] = incons_slot2;
    assign incons[3] = incons_slot3;

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_lane
        rshm_lane u_lane (
            .id          (ids[g]),
            .primary_dev (primary_device),
            .healthy     (healthy_mask[g]),
            .incons      (incons[g]),
            .res         (lane_res[g])
        );
    end

    // Advance the pipeline.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_lanes_reg <= lane_res;
            s1_time_reg  <= time_us;
        end
    end

    // Merge what the lanes found.
    rshm_merge u_merge (
        .lanes          (s1_lanes_reg),
        .warn_level     (warn_level_reg),
        .critical_level (critical_level_reg),
        .margin_ratio   (margin_ratio_reg),
        .res            (merged)
    );

    // Filter the raw failure: hold time to set, clear at once.
    always_comb
    begin
        req_next      = req_reg;
        req_time_next = req_time_reg;
        filt_next     = filt_reg;
        if (merged.raw_failure != filt_reg)
        begin
            if (merged.raw_failure != req_reg)
            begin
                req_next      = merged.raw_failure;
                req_time_next = s1_time_reg;
            end
        end
        else
        begin
            req_next = filt_reg;
        end
        elapsed = s1_time_reg - req_time_next;
        if (req_next != filt_reg)
        begin
            if (filt_reg)
            begin
                filt_next = 1'b0;
            end
            else if (elapsed >= TIME_W'(hold_time_us_reg))
            begin
                filt_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg     <= 1'b0;
            req_reg      <= 1'b0;
            req_time_reg <= '0;
        end
        else if (s1_adv)
        begin
            filt_reg     <= filt_next;
            req_reg      <= req_next;
            req_time_reg <= req_time_next;
        end
    end

    // Load the result register; drop valid once taken.
    always_comb
    begin
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            raw_reg <= merged.raw_failure;
            ok_reg  <= !filt_next;
            sev_reg <= filt_next ? merged.severity : SEV_INFO;
            low_reg <= filt_next && merged.low_margin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign raw_failure = raw_reg;
    assign ok_flag     = ok_reg;
    assign severity    = sev_reg;
    assign low_margin  = low_reg;

    // A clear filter reports info with high margin.
    `RSHM_ASSERT_IMP(a_ok_quiet, clk, rst_n, out_valid_reg && ok_reg, (sev_reg == SEV_INFO) && !low_reg, "ok result with nonzero severity or low margin")
    // A set filter implies a raw failure on the same update.
    `RSHM_ASSERT_IMP(a_fail_raw, clk, rst_n, out_valid_reg && !ok_reg, raw_reg, "filtered failure without raw failure")
    // Critical severity always reports low margin.
    `RSHM_ASSERT_IMP(a_crit_low, clk, rst_n, out_valid_reg && (sev_reg == SEV_CRITICAL), low_reg, "critical result with high margin")
    // The filter changes only when a request moves to the output.
    `RSHM_ASSERT_NXT(a_filt_hold, clk, rst_n, !s1_adv, $stable(filt_reg), "filter state changed without a request")

endmodule

`default_nettype wire
